// ----- hdl/fst_pkg.sv -----
// Shared types and constants for the FCFS schedule timing block.
// No dependencies; every other file refers to this package by scoped names.
package fst_pkg;

    localparam int TIME_W        = 16;  // arrival and burst width
    localparam int CLK_W         = 23;  // completion, turnaround, wait width
    localparam int SLOT_W        = 6;   // slot field width
    localparam int MAX_PROCS_DEF = 64;  // default record capacity

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
    } t_rec;

    typedef struct packed {
        logic [CLK_W-1:0] completion;
        logic [CLK_W-1:0] turnaround;
        logic [CLK_W-1:0] wait_t;
    } t_times;

endpackage

// ----- hdl/fst_in_if.sv -----
// Request channel carrying one process record.
// Depends on fst_pkg for field widths.
interface fst_in_if;
    logic                        valid;
    logic                        ready;
    logic [fst_pkg::TIME_W-1:0]  arrive_at;
    logic [fst_pkg::TIME_W-1:0]  service_len;
    logic                        last_record;

    modport source (output valid, arrive_at, service_len, last_record, input ready);
    modport sink   (input valid, arrive_at, service_len, last_record, output ready);
endinterface

// ----- hdl/fst_out_if.sv -----
// Result channel carrying one scheduled process's timing.
// Depends on fst_pkg for field widths.
interface fst_out_if;
    logic                        valid;
    logic                        ready;
    logic [fst_pkg::SLOT_W-1:0]  slot;
    logic [fst_pkg::TIME_W-1:0]  start_arrival;
    logic [fst_pkg::CLK_W-1:0]   finish_at;
    logic [fst_pkg::CLK_W-1:0]   turnaround;
    logic [fst_pkg::CLK_W-1:0]   queue_delay;
    logic                        overflow;
    logic                        last_result;

    modport source (output valid, slot, start_arrival, finish_at, turnaround,
                    queue_delay, overflow, last_result, input ready);
    modport sink   (input valid, slot, start_arrival, finish_at, turnaround,
                    queue_delay, overflow, last_result, output ready);
endinterface

// ----- hdl/fst_ram.sv -----
// Record store: one write port, one read port with registered read data.
// Depends on fst_pkg for the record type.
module fst_ram #(
    parameter int DEPTH = fst_pkg::MAX_PROCS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  fst_pkg::t_rec    i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output fst_pkg::t_rec    o_rdata
);

    fst_pkg::t_rec r_mem [DEPTH];
    fst_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/fst_calc.sv -----
// Timing arithmetic for one served process: raise clock to arrival, add burst.
// Depends on fst_pkg for widths and the t_times result group.
module fst_calc (
    input  logic [fst_pkg::CLK_W-1:0]  i_clock,
    input  fst_pkg::t_rec              i_rec,
    output fst_pkg::t_times            o_times
);

    logic [fst_pkg::CLK_W-1:0] arr_ext;
    logic [fst_pkg::CLK_W-1:0] bur_ext;
    logic [fst_pkg::CLK_W-1:0] start;

    assign arr_ext = {{(fst_pkg::CLK_W-fst_pkg::TIME_W){1'b0}}, i_rec.arrival};
    assign bur_ext = {{(fst_pkg::CLK_W-fst_pkg::TIME_W){1'b0}}, i_rec.burst};

    // Start of service: idle clock jumps forward to the arrival.
    assign start = (i_clock < arr_ext) ? arr_ext : i_clock;

    always_comb begin
        o_times.completion = start + bur_ext;
        o_times.turnaround = o_times.completion - arr_ext;
        o_times.wait_t     = start - arr_ext;
    end

endmodule

// ----- hdl/fcfs_schedule_timing.sv -----
// First-come-first-served schedule timing. Records (arrival, burst) are taken
// one request at a time and kept in arrival order by insertion: a new record
// is compared against the stored ones from the tail down with a single
// comparator, moving one record per cycle through the one-read/one-write record
// store; a record arriving with the store empty is written straight to the head.
// A record arriving with the store full is dropped and flags overflow. The
// record marked last closes the set: the block then serves the set through one
// shared timing unit, reading one record, computing its completion, turnaround
// and wait, and holding it on the result channel until it is taken. No new
// request is taken while a record is being placed or while the results of a
// set are being delivered.
// Depends on fst_pkg, fst_in_if, fst_out_if, fst_ram and fst_calc.
module fcfs_schedule_timing #(
    parameter int MAX_PROCS = fst_pkg::MAX_PROCS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fst_in_if.sink     i_in,
    fst_out_if.source  o_out
);

    localparam int AW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int SW = fst_pkg::SLOT_W;

    // Sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;  // take a request
    localparam logic [2:0] S_SCAN  = 3'd1;  // compare tail record, shift it up
    localparam logic [2:0] S_PLACE = 3'd2;  // write new record at the head
    localparam logic [2:0] S_ORD   = 3'd3;  // read record for the next result
    localparam logic [2:0] S_OCALC = 3'd4;  // compute timing, load result
    localparam logic [2:0] S_OHOLD = 3'd5;  // hold result until taken

    logic [2:0]                 r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_dropped, n_dropped;
    logic [AW-1:0]              r_j, n_j;        // insertion target position
    logic [AW-1:0]              r_k, n_k;        // result index
    fst_pkg::t_rec              r_new, n_new;    // record being inserted
    logic                       r_last, n_last;  // set closes after insertion
    logic [fst_pkg::CLK_W-1:0]  r_clock, n_clock;

    // Result register
    logic                       r_ovalid, n_ovalid;
    logic                       r_olast, n_olast;
    logic [fst_pkg::SLOT_W-1:0] r_slot;
    logic [fst_pkg::TIME_W-1:0] r_arr;
    fst_pkg::t_times            r_times;

    // Store ports
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    fst_pkg::t_rec              mem_wdata;
    logic [AW-1:0]              mem_raddr;
    fst_pkg::t_rec              mem_rdata;

    fst_pkg::t_rec              in_rec;
    fst_pkg::t_times            calc_times;
    logic                       in_fire;
    logic                       out_fire;
    logic                       load_out;
    logic                       is_last_k;

    assign in_rec.arrival = i_in.arrive_at;
    assign in_rec.burst   = i_in.service_len;
    assign i_in.ready     = (r_state == S_IDLE);
    assign in_fire        = i_in.valid && i_in.ready;
    assign out_fire       = o_out.valid && o_out.ready;
    assign load_out       = (r_state == S_OCALC);
    assign is_last_k      = (CW'(r_k) + CW'(1)) == r_count;

    fst_ram #(
        .DEPTH (MAX_PROCS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    fst_calc u_calc (
        .i_clock (r_clock),
        .i_rec   (mem_rdata),
        .o_times (calc_times)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_j       = r_j;
        n_k       = r_k;
        n_new     = r_new;
        n_last    = r_last;
        n_clock   = r_clock;
        n_ovalid  = r_ovalid;
        n_olast   = r_olast;
        mem_we    = 1'b0;
        mem_waddr = r_j;
        mem_wdata = r_new;
        mem_raddr = r_k;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_new  = in_rec;
                    n_last = i_in.last_record;
                    n_k    = '0;
                    priority if (r_count == CW'(MAX_PROCS)) begin
                        // Store full: drop the record, flag the set.
                        n_dropped = 1'b1;
                        if (i_in.last_record) begin
                            n_state = S_ORD;
                        end
                    end else if (r_count == '0) begin
                        // Empty store: write straight to the head.
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = in_rec;
                        n_count   = CW'(1);
                        if (i_in.last_record) begin
                            n_state = S_ORD;
                        end
                    end else begin
                        // Start at the tail; fetch the last stored record.
                        n_j       = r_count[AW-1:0];
                        mem_raddr = AW'(r_count - CW'(1));
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                mem_we = 1'b1;
                if (mem_rdata.arrival > r_new.arrival) begin
                    // Shift the later arrival up one place, keep scanning.
                    mem_waddr = r_j;
                    mem_wdata = mem_rdata;
                    n_j       = r_j - AW'(1);
                    mem_raddr = r_j - AW'(2);
                    if (r_j == AW'(1)) begin
                        n_state = S_PLACE;
                    end
                end else begin
                    // Equal or earlier arrival stays ahead: place here.
                    mem_waddr = r_j;
                    mem_wdata = r_new;
                    n_count   = r_count + CW'(1);
                    n_state   = r_last ? S_ORD : S_IDLE;
                end
            end
            S_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_new;
                n_count   = r_count + CW'(1);
                n_state   = r_last ? S_ORD : S_IDLE;
            end
            S_ORD: begin
                mem_raddr = r_k;
                n_state   = S_OCALC;
            end
            S_OCALC: begin
                // Advance the service clock and present the result.
                n_clock  = calc_times.completion;
                n_ovalid = 1'b1;
                n_olast  = is_last_k;
                n_state  = S_OHOLD;
            end
            S_OHOLD: begin
                if (out_fire) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        // Set done: clear for the next set.
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_clock   = '0;
                        n_state   = S_IDLE;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_clock   <= '0;
            r_ovalid  <= 1'b0;
            r_olast   <= 1'b0;
            r_j       <= '0;
            r_k       <= '0;
            r_last    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_clock   <= n_clock;
            r_ovalid  <= n_ovalid;
            r_olast   <= n_olast;
            r_j       <= n_j;
            r_k       <= n_k;
            r_last    <= n_last;
        end
    end

    // Result payload: no reset needed.
    always_ff @(posedge i_clk) begin
        r_new <= n_new;
        if (load_out) begin
            r_slot  <= SW'(r_k);
            r_arr   <= mem_rdata.arrival;
            r_times <= calc_times;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.slot          = r_slot;
    assign o_out.start_arrival = r_arr;
    assign o_out.finish_at     = r_times.completion;
    assign o_out.turnaround    = r_times.turnaround;
    assign o_out.queue_delay   = r_times.wait_t;
    assign o_out.overflow      = r_dropped;
    assign o_out.last_result   = r_olast;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PROCS))
        else $error("record count exceeds capacity");

    a_scan_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_j != '0))
        else $error("scan reached head without placement");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("request taken while a result is pending");

    a_set_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_out.last_result) |=> (r_count == '0 && !r_dropped))
        else $error("set state not cleared after final result");

    a_next_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !o_out.last_result) |=> (r_state == S_ORD && r_k == $past(r_k) + AW'(1)))
        else $error("result index did not advance");
`endif

endmodule

// ----- dv/tb_fcfs_schedule_timing.sv -----
// Self-checking testbench for fcfs_schedule_timing: random process record sets in bursts,
// checked one result at a time against an in-bench FCFS schedule calculator.
// Depends on fst_pkg, fst_in_if, fst_out_if and the block under test.
module tb_fcfs_schedule_timing;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_W    = fst_pkg::TIME_W;
    localparam int CLK_W     = fst_pkg::CLK_W;
    localparam int SLOT_W    = fst_pkg::SLOT_W;
    localparam int CAPACITY  = fst_pkg::MAX_PROCS_DEF;
    localparam int RAND_RECS = 480;

    // One scheduled process as it should leave the result channel.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] start_arrival;
        logic [CLK_W-1:0]  completion;
        logic [CLK_W-1:0]  turnaround;
        logic [CLK_W-1:0]  wait_t;
        logic              overflow;
        logic              last_result;
    } t_timing_row;

    // Holds the records of the open set, computes the FCFS timing of a set once it
    // closes, and checks delivered results against the oldest pending timing row.
    class schedule_book;
        logic [TIME_W-1:0] arr_buf [CAPACITY];
        logic [TIME_W-1:0] bur_buf [CAPACITY];
        int unsigned       held;
        bit                dropped;
        t_timing_row       timing_due[$];
        int unsigned       faults;

        function new();
            held    = 0;
            dropped = 1'b0;
            faults  = 0;
        endfunction

        function void note_record(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b, logic l);
            logic [TIME_W-1:0] ka;
            logic [TIME_W-1:0] kb;
            logic [CLK_W-1:0]  clk_t;
            logic [CLK_W-1:0]  comp;
            t_timing_row       row;
            int                j;
            // Store while there is room, otherwise drop and flag the set.
            if (held < CAPACITY) begin
                arr_buf[held] = a;
                bur_buf[held] = b;
                held++;
            end else begin
                dropped = 1'b1;
            end
            if (!l)
                return;
            // Stable insertion sort: equal arrivals keep their request order.
            for (int i = 1; i < held; i++) begin
                ka = arr_buf[i];
                kb = bur_buf[i];
                j  = i;
                while (j > 0 && arr_buf[j-1] > ka) begin
                    arr_buf[j] = arr_buf[j-1];
                    bur_buf[j] = bur_buf[j-1];
                    j--;
                end
                arr_buf[j] = ka;
                bur_buf[j] = kb;
            end
            // Serve in order; raise the running clock to each arrival when idle.
            clk_t = '0;
            for (int k = 0; k < held; k++) begin
                if (clk_t < CLK_W'(arr_buf[k]))
                    clk_t = CLK_W'(arr_buf[k]);
                comp              = clk_t + CLK_W'(bur_buf[k]);
                row.slot          = SLOT_W'(k);
                row.start_arrival = arr_buf[k];
                row.completion    = comp;
                row.turnaround    = comp - CLK_W'(arr_buf[k]);
                row.wait_t        = row.turnaround - CLK_W'(bur_buf[k]);
                row.overflow      = dropped;
                row.last_result   = (k == held - 1);
                timing_due.push_back(row);
                clk_t = comp;
            end
            held    = 0;
            dropped = 1'b0;
        endfunction

        function void check_timing(t_timing_row got);
            t_timing_row want;
            if (timing_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: slot %0d arrival %0d completion %0d",
                             got.slot, got.start_arrival, got.completion);
                return;
            end
            want = timing_due.pop_front();
            if (got !== want) begin
                faults++;
                if (faults <= 10) begin
                    $display("mismatch: slot exp %0d got %0d, arrival exp %0d got %0d",
                             want.slot, got.slot, want.start_arrival, got.start_arrival);
                    $display("  completion exp %0d got %0d, turnaround exp %0d got %0d",
                             want.completion, got.completion, want.turnaround,
                             got.turnaround);
                    $display("  wait exp %0d got %0d, overflow exp %0b got %0b, last exp %0b got %0b",
                             want.wait_t, got.wait_t, want.overflow, got.overflow,
                             want.last_result, got.last_result);
                end
            end
        endfunction

        function int pending();
            return timing_due.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    fst_in_if  in_if();
    fst_out_if out_if();

    fcfs_schedule_timing dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    schedule_book sched_book = new();
    int           burst_left = 0;
    int           sent_recs  = 0;

    // Present one request and hold it until the block takes it. Between bursts,
    // drop valid for a random gap; inside a burst keep valid high for the next one.
    task automatic send_record(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b,
                               input logic l);
        int gap;
        in_if.valid       <= 1'b1;
        in_if.arrive_at   <= a;
        in_if.service_len <= b;
        in_if.last_record <= l;
        do @(posedge i_clk); while (!in_if.ready);
        sched_book.note_record(a, b, l);
        sent_recs++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Hold off the sender until every pending result has been delivered.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sched_book.pending() != 0);
    endtask

    // Send one set of n records with random content; the n-th closes the set.
    // Arrivals mix full range, a narrow range (many ties), the extremes and a
    // cluster near a per-set base; bursts lean small so the clock often idles.
    task automatic send_set(input int n);
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic [TIME_W-1:0] base;
        int                sel;
        base = TIME_W'($urandom);
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
                a = TIME_W'($urandom);
            else if (sel < 7)
                a = TIME_W'($urandom_range(0, 31));
            else if (sel == 7)
                a = $urandom_range(0, 1) ? '1 : '0;
            else
                a = base + TIME_W'($urandom_range(0, 3));
            sel = $urandom_range(0, 9);
            if (sel < 5)
                b = TIME_W'($urandom_range(0, 255));
            else if (sel < 8)
                b = TIME_W'($urandom);
            else if (sel == 8)
                b = '0;
            else
                b = '1;
            send_record(a, b, i == n - 1);
        end
    endtask

    // Result side: stall on a pattern of its own - open stretches, coin-flip
    // stretches and hard stalls of random length.
    initial begin
        int mode;
        int len;
        out_if.ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(1, 20);
            repeat (len) begin
                @(posedge i_clk);
                case (mode)
                    0: begin
                        out_if.ready <= 1'b1;
                    end
                    1: begin
                        out_if.ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        out_if.ready <= 1'b0;
                    end
                endcase
            end
        end
    end

    // Check every result the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sched_book.check_timing(t_timing_row'{
                slot:          out_if.slot,
                start_arrival: out_if.start_arrival,
                completion:    out_if.finish_at,
                turnaround:    out_if.turnaround,
                wait_t:        out_if.queue_delay,
                overflow:      out_if.overflow,
                last_result:   out_if.last_result
            });
    end

    initial begin
        int sel;
        int n;
        in_if.valid       <= 1'b0;
        in_if.arrive_at   <= '0;
        in_if.service_len <= '0;
        in_if.last_record <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-record sets at both extremes.
        send_record('0, '0, 1'b1);
        send_record('1, '1, 1'b1);
        // Reverse order with tied arrivals: ties must keep request order.
        send_record(16'd500, 16'd10, 1'b0);
        send_record(16'd100, 16'd50, 1'b0);
        send_record(16'd100, 16'd20, 1'b0);
        send_record(16'd100, 16'd0, 1'b0);
        send_record(16'd0, '1, 1'b1);
        // Idle gaps where the clock must jump up to the next arrival.
        send_record(16'd1000, 16'd5, 1'b0);
        send_record(16'd10, 16'd5, 1'b0);
        send_record('1, '0, 1'b0);
        send_record(16'd20000, '1, 1'b1);
        // All maximum: largest completion times.
        send_record('1, '1, 1'b0);
        send_record('1, '1, 1'b0);
        send_record('1, '1, 1'b1);
        // All zero.
        send_record('0, '0, 1'b0);
        send_record('0, '0, 1'b1);
        drain_results();

        // Store full: one set whose closing record is dropped, one exactly full.
        send_set(CAPACITY + 1);
        send_set(CAPACITY);
        drain_results();

        // Random sets: mostly small, a few at or beyond capacity.
        while (sent_recs < RAND_RECS) begin
            sel = $urandom_range(0, 19);
            if (sel < 14)
                n = $urandom_range(1, 8);
            else if (sel < 16)
                n = $urandom_range(9, 40);
            else if (sel < 18)
                n = CAPACITY;
            else
                n = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            send_set(n);
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end
        in_if.valid <= 1'b0;

        // Wait out the remaining results, then a quiet tail for stray ones.
        while (sched_book.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sched_book.faults == 0 && sched_book.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
